// ----- hdl/gfe_pkg.sv -----
// ---------------------------------------------------------------------------
// gfe_pkg: shared types and constants of the fire escape grid search
// Grid limits, derived widths, cell kind codes and inter-module records.
// ---------------------------------------------------------------------------
package gfe_pkg;

    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 256;
    localparam int CELLS_MAX = MAX_ROWS * MAX_COLS;

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int IDX_W = $clog2(CELLS_MAX);
    localparam int CNT_W = IDX_W + 1;
    localparam int TIME_W = IDX_W + 1;
    localparam int DR_W = ROW_W + 1;
    localparam int DC_W = COL_W + 1;
    localparam int CFG_W = 9;
    localparam int KIND_W = 3;

    // Cell word: kind, walker visited flag, fire arrival time.
    localparam int CELL_WORD_W = KIND_W + 1 + TIME_W;
    // Queue word: row, column, linear index, arrival time.
    localparam int QUEUE_WORD_W = ROW_W + COL_W + IDX_W + TIME_W;

    localparam logic [TIME_W-1:0] TIME_INF = '1;

    localparam logic [KIND_W-1:0] KIND_WALL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_START = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXIT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIRE = 3'd4;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef struct packed {
        logic [DR_W-1:0]  rows;
        logic [DC_W-1:0]  cols;
        logic [CNT_W-1:0] cells;
    } t_geom;

    typedef struct packed {
        logic valid;
        logic escape;
    } t_eng_res;

endpackage

// ----- hdl/gfe_ram.sv -----
// ---------------------------------------------------------------------------
// gfe_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module gfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/gfe_engine.sv -----
// ---------------------------------------------------------------------------
// gfe_engine: grid loader and breadth-first search sequencer
// Loads cells into the cell memory, then runs the fire pass and the walker
// pass through a queue memory, one neighbor read-modify-write at a time.
// ---------------------------------------------------------------------------
module gfe_engine import gfe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_geom             i_geom,
    input  logic              i_in_valid,
    input  logic [KIND_W-1:0] i_cell_kind,
    input  logic              i_last_cell,
    output logic              o_in_stall,
    input  logic              i_out_free,
    output t_eng_res          o_res
);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT_RD, S_INIT_WR, S_POP_RD, S_POP_WR, S_NB_RD, S_NB_WR,
        S_DIV, S_START_RD, S_START_WR, S_DONE
    } t_state;

    t_state r_state;
    logic [CNT_W-1:0] r_load_pos;
    logic [IDX_W-1:0] r_start;
    logic [IDX_W-1:0] r_ptr;
    logic [ROW_W-1:0] r_r;
    logic [COL_W-1:0] r_c;
    logic [CNT_W-1:0] r_head;
    logic [CNT_W-1:0] r_tail;
    logic             r_walk;
    logic [2:0]       r_j;
    logic [ROW_W-1:0] r_x_row;
    logic [COL_W-1:0] r_x_col;
    logic [IDX_W-1:0] r_x_idx;
    logic [TIME_W-1:0] r_x_time;
    logic [ROW_W-1:0] r_y_row;
    logic [COL_W-1:0] r_y_col;
    logic [IDX_W-1:0] r_y_idx;
    logic [CNT_W-1:0] r_rem;
    logic [ROW_W-1:0] r_sr;
    logic [COL_W-1:0] r_sc;
    logic             r_escape;

    logic                    c_we;
    logic [IDX_W-1:0]        c_waddr;
    logic [CELL_WORD_W-1:0]  c_wdata;
    logic [IDX_W-1:0]        c_raddr;
    logic [CELL_WORD_W-1:0]  c_rdata;
    logic                    q_we;
    logic [IDX_W-1:0]        q_waddr;
    logic [QUEUE_WORD_W-1:0] q_wdata;
    logic [IDX_W-1:0]        q_raddr;
    logic [QUEUE_WORD_W-1:0] q_rdata;

    logic [KIND_W-1:0] rd_kind;
    logic              rd_vis;
    logic [TIME_W-1:0] rd_fire;
    logic [TIME_W-1:0] t_next;
    logic              accept;
    logic              load_ok;
    logic              fire_push;
    logic              walk_exit;
    logic              walk_push;
    logic              nb_ok;
    logic [ROW_W-1:0]  nb_row;
    logic [COL_W-1:0]  nb_col;
    logic [IDX_W-1:0]  nb_idx;

    gfe_ram #(.WIDTH(CELL_WORD_W), .DEPTH(CELLS_MAX)) u_cell_ram (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );

    gfe_ram #(.WIDTH(QUEUE_WORD_W), .DEPTH(CELLS_MAX)) u_queue_ram (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    // Fields of the cell word just read and the candidate arrival time.
    assign rd_kind = c_rdata[CELL_WORD_W-1 -: KIND_W];
    assign rd_vis = c_rdata[TIME_W];
    assign rd_fire = c_rdata[TIME_W-1:0];
    assign t_next = r_x_time + TIME_W'(1);

    assign o_in_stall = (r_state != S_IDLE);
    assign accept = i_in_valid && (r_state == S_IDLE);
    assign load_ok = (r_load_pos < i_geom.cells);

    // Neighbor decisions for the two passes.
    assign fire_push = !r_walk && (rd_kind != KIND_WALL) && (rd_fire == TIME_INF);
    assign walk_exit = r_walk && (rd_kind == KIND_EXIT) && (t_next <= rd_fire);
    assign walk_push = r_walk && (rd_kind != KIND_WALL) && !walk_exit && !rd_vis &&
                       (t_next < rd_fire);

    // Neighbor selection: up, left, down, right.
    always_comb begin
        nb_ok = 1'b0;
        nb_row = r_x_row;
        nb_col = r_x_col;
        nb_idx = r_x_idx;
        case (r_j)
            3'd0: begin
                nb_ok = (r_x_row != '0);
                nb_row = r_x_row - ROW_W'(1);
                nb_idx = IDX_W'(CNT_W'(r_x_idx) - CNT_W'(i_geom.cols));
            end
            3'd1: begin
                nb_ok = (r_x_col != '0);
                nb_col = r_x_col - COL_W'(1);
                nb_idx = r_x_idx - IDX_W'(1);
            end
            3'd2: begin
                nb_ok = ((DR_W'(r_x_row) + DR_W'(1)) < i_geom.rows);
                nb_row = r_x_row + ROW_W'(1);
                nb_idx = IDX_W'(CNT_W'(r_x_idx) + CNT_W'(i_geom.cols));
            end
            3'd3: begin
                nb_ok = ((DC_W'(r_x_col) + DC_W'(1)) < i_geom.cols);
                nb_col = r_x_col + COL_W'(1);
                nb_idx = r_x_idx + IDX_W'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // Memory port control.
    always_comb begin
        c_we = 1'b0;
        c_waddr = r_ptr;
        c_wdata = {rd_kind, rd_vis, rd_fire};
        c_raddr = r_ptr;
        q_we = 1'b0;
        q_waddr = r_tail[IDX_W-1:0];
        q_wdata = {r_y_row, r_y_col, r_y_idx, t_next};
        q_raddr = r_head[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                c_we = accept && load_ok;
                c_waddr = r_load_pos[IDX_W-1:0];
                c_wdata = {i_cell_kind, 1'b0, TIME_INF};
            end
            S_INIT_WR: begin
                c_we = 1'b1;
                c_wdata = {rd_kind, 1'b0,
                           (rd_kind == KIND_FIRE) ? TIME_W'(0) : TIME_INF};
                q_we = (rd_kind == KIND_FIRE);
                q_wdata = {r_r, r_c, r_ptr, TIME_W'(0)};
            end
            S_NB_RD: begin
                c_raddr = nb_idx;
            end
            S_NB_WR: begin
                c_waddr = r_y_idx;
                c_we = fire_push || walk_push;
                q_we = fire_push || walk_push;
                c_wdata = r_walk ? {rd_kind, 1'b1, rd_fire} : {rd_kind, rd_vis, t_next};
            end
            S_START_RD: begin
                c_raddr = r_start;
            end
            S_START_WR: begin
                c_we = 1'b1;
                c_waddr = r_start;
                c_wdata = {rd_kind, 1'b1, rd_fire};
                q_we = 1'b1;
                q_wdata = {r_sr, r_sc, r_start, TIME_W'(0)};
            end
            default: begin
                c_we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_load_pos <= '0;
            r_start <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_walk <= 1'b0;
            r_escape <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (load_ok && (i_cell_kind == KIND_START)) begin
                            r_start <= r_load_pos[IDX_W-1:0];
                        end
                        if (i_last_cell) begin
                            r_load_pos <= '0;
                            r_ptr <= '0;
                            r_r <= '0;
                            r_c <= '0;
                            r_head <= '0;
                            r_tail <= '0;
                            r_walk <= 1'b0;
                            r_state <= S_INIT_RD;
                        end else if (load_ok) begin
                            r_load_pos <= r_load_pos + CNT_W'(1);
                        end
                    end
                end
                S_INIT_RD: begin
                    r_state <= S_INIT_WR;
                end
                S_INIT_WR: begin
                    if (rd_kind == KIND_FIRE) begin
                        r_tail <= r_tail + CNT_W'(1);
                    end
                    if ((DC_W'(r_c) + DC_W'(1)) == i_geom.cols) begin
                        r_c <= '0;
                        r_r <= r_r + ROW_W'(1);
                    end else begin
                        r_c <= r_c + COL_W'(1);
                    end
                    r_ptr <= r_ptr + IDX_W'(1);
                    if ((CNT_W'(r_ptr) + CNT_W'(1)) == i_geom.cells) begin
                        r_state <= S_POP_RD;
                    end else begin
                        r_state <= S_INIT_RD;
                    end
                end
                S_POP_RD: begin
                    if (r_head == r_tail) begin
                        if (r_walk || (CNT_W'(r_start) >= i_geom.cells)) begin
                            r_escape <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_rem <= CNT_W'(r_start);
                            r_sr <= '0;
                            r_head <= '0;
                            r_tail <= '0;
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_head <= r_head + CNT_W'(1);
                        r_state <= S_POP_WR;
                    end
                end
                S_POP_WR: begin
                    {r_x_row, r_x_col, r_x_idx, r_x_time} <= q_rdata;
                    r_j <= '0;
                    r_state <= S_NB_RD;
                end
                S_NB_RD: begin
                    if (r_j == 3'd4) begin
                        r_state <= S_POP_RD;
                    end else begin
                        r_j <= r_j + 3'd1;
                        if (nb_ok) begin
                            r_y_row <= nb_row;
                            r_y_col <= nb_col;
                            r_y_idx <= nb_idx;
                            r_state <= S_NB_WR;
                        end
                    end
                end
                S_NB_WR: begin
                    if (fire_push || walk_push) begin
                        r_tail <= r_tail + CNT_W'(1);
                    end
                    if (walk_exit) begin
                        r_escape <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_NB_RD;
                    end
                end
                S_DIV: begin
                    // Row of the start cell by repeated subtraction.
                    if (r_rem >= CNT_W'(i_geom.cols)) begin
                        r_rem <= r_rem - CNT_W'(i_geom.cols);
                        r_sr <= r_sr + ROW_W'(1);
                    end else begin
                        r_sc <= r_rem[COL_W-1:0];
                        r_state <= S_START_RD;
                    end
                end
                S_START_RD: begin
                    r_state <= S_START_WR;
                end
                S_START_WR: begin
                    r_tail <= CNT_W'(1);
                    r_walk <= 1'b1;
                    r_state <= S_POP_RD;
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid = (r_state == S_DONE) && i_out_free;
    assign o_res.escape = r_escape;

endmodule

// ----- hdl/grid_fire_escape_bfs.sv -----
// ---------------------------------------------------------------------------
// grid_fire_escape_bfs: fire escape search over a loaded grid
// Configuration, grid geometry and the result register around the engine.
// ---------------------------------------------------------------------------
// Cells load one request per cycle in row-major order. The request marked
// last_cell starts the search and the block stalls its input until the
// answer is produced: initialization reads and rewrites every cell, then in
// each of the two passes a cell is taken from the queue, its four neighbor
// slots and a last check are stepped through, and every neighbor inside the
// grid gets a read-modify-write step; between the passes the start cell is
// located by repeated subtraction and seeded. The cell memory, with one
// read and one write port and visited by one read-modify-write at a time,
// paces these steps. The answer waits in an output register, so loading of
// the next grid can proceed meanwhile.
module grid_fire_escape_bfs import gfe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [KIND_W-1:0] i_cell_kind,
    input  logic              i_last_cell,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_escape_possible
);

    logic [CFG_W-1:0] r_rows;
    logic [CFG_W-1:0] r_cols;
    logic             r_out_valid;
    logic             r_escape;
    t_geom            geom;
    t_eng_res         eng_res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_W'(256);
            r_cols <= CFG_W'(256);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ROWS) begin
                r_rows <= i_cfg_data;
            end else if (i_cfg_idx == CFG_COLS) begin
                r_cols <= i_cfg_data;
            end
        end
    end

    // Effective dimensions, clamped to one and to the grid limits.
    always_comb begin
        if (r_rows == '0) begin
            geom.rows = DR_W'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            geom.rows = DR_W'(MAX_ROWS);
        end else begin
            geom.rows = DR_W'(r_rows);
        end
        if (r_cols == '0) begin
            geom.cols = DC_W'(1);
        end else if (32'(r_cols) > MAX_COLS) begin
            geom.cols = DC_W'(MAX_COLS);
        end else begin
            geom.cols = DC_W'(r_cols);
        end
        geom.cells = CNT_W'(geom.rows * geom.cols);
    end

    gfe_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_geom(geom),
        .i_in_valid(i_in_valid), .i_cell_kind(i_cell_kind),
        .i_last_cell(i_last_cell), .o_in_stall(o_in_stall),
        .i_out_free(!r_out_valid || !i_out_stall), .o_res(eng_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_res.valid) begin
            r_escape <= eng_res.escape;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_escape_possible = r_escape;

`ifndef SYNTHESIS
    // A new answer never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_res.valid |-> (!r_out_valid || !i_out_stall))
        else $error("answer produced while result register busy");

    // The last cell of a grid starts the search, which stalls the input.
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_cell) |=> o_in_stall)
        else $error("input not stalled after last cell");

    // Once an answer is handed over, loading resumes.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_res.valid |=> (!o_in_stall && o_out_valid))
        else $error("engine not idle after answer");
`endif

endmodule

// ----- test/grid_fire_escape_bfs_test.sv -----
// ---------------------------------------------------------------------------
// grid_fire_escape_bfs_test: self-checking bench for the fire escape search
// Loads grids under several geometries, predicts each escape answer with a
// behavioral two-pass search, and compares every answer with the block's.
// ---------------------------------------------------------------------------
module grid_fire_escape_bfs_test;
    import gfe_pkg::*;

    localparam logic [KIND_W-1:0] KIND_OPEN = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam int TIME_NEVER = 32'h7fffffff;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_cell_req;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [KIND_W-1:0] i_cell_kind;
    logic              i_last_cell;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_escape_possible;

    grid_fire_escape_bfs dut (.*);

    // Requests waiting to be sent and answers waiting to arrive.
    t_cell_req cell_q[$];
    bit        escape_q[$];

    // Predictor state.
    logic [CFG_W-1:0]  rows_cfg;
    logic [CFG_W-1:0]  cols_cfg;
    logic [KIND_W-1:0] grid_mem[CELLS_MAX];
    int                fire_at[CELLS_MAX];
    int                walk_at[CELLS_MAX];
    int                bfs_q[CELLS_MAX];
    int                start_pos;
    int                load_pos;

    // Generator view of which cells hold a known kind.
    bit gen_written[CELLS_MAX];
    int gen_pos;
    int gen_cells;

    int errors;
    int idle_left;
    int hold_left;
    bit send_quiet;
    bit recv_quiet;
    int pressure_left;
    bit pressure_req;
    bit pressure_ack;

    // The clock.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int eff_dim(input logic [CFG_W-1:0] v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Random wait length, with occasional runs of no waiting at all.
    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 60) == 0) quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic int edge_nbrs(input int x, input int rows, input int cols,
                                     output int nb[4]);
        int r;
        int c;
        int k;
        r = x / cols;
        c = x % cols;
        k = 0;
        if (r > 0) begin nb[k] = x - cols; k++; end
        if (c > 0) begin nb[k] = x - 1; k++; end
        if (r + 1 < rows) begin nb[k] = x + cols; k++; end
        if (c + 1 < cols) begin nb[k] = x + 1; k++; end
        return k;
    endfunction

    // Fire spread from every source, then the walker's search from the start.
    function automatic bit escape_found(input int rows, input int cols);
        int cells;
        int head;
        int tail;
        int x;
        int y;
        int t;
        int k;
        int nb[4];
        cells = rows * cols;
        head = 0;
        tail = 0;
        for (int i = 0; i < cells; i++) begin
            fire_at[i] = TIME_NEVER;
            if (grid_mem[i] == KIND_FIRE) begin
                fire_at[i] = 0;
                bfs_q[tail++] = i;
            end
        end
        while (head < tail) begin
            x = bfs_q[head++];
            k = edge_nbrs(x, rows, cols, nb);
            for (int j = 0; j < k; j++) begin
                y = nb[j];
                if (grid_mem[y] != KIND_WALL && fire_at[y] == TIME_NEVER) begin
                    fire_at[y] = fire_at[x] + 1;
                    bfs_q[tail++] = y;
                end
            end
        end
        if (start_pos >= cells) return 1'b0;
        for (int i = 0; i < cells; i++) walk_at[i] = TIME_NEVER;
        head = 0;
        tail = 0;
        walk_at[start_pos] = 0;
        bfs_q[tail++] = start_pos;
        while (head < tail) begin
            x = bfs_q[head++];
            k = edge_nbrs(x, rows, cols, nb);
            t = walk_at[x] + 1;
            for (int j = 0; j < k; j++) begin
                y = nb[j];
                if (grid_mem[y] == KIND_WALL) continue;
                if (grid_mem[y] == KIND_EXIT && t <= fire_at[y]) return 1'b1;
                if (walk_at[y] == TIME_NEVER && t < fire_at[y]) begin
                    walk_at[y] = t;
                    bfs_q[tail++] = y;
                end
            end
        end
        return 1'b0;
    endfunction

    // Store one accepted cell and, on the last one, predict the answer.
    function automatic void load_cell(input t_cell_req req);
        int rows;
        int cols;
        rows = eff_dim(rows_cfg, MAX_ROWS);
        cols = eff_dim(cols_cfg, MAX_COLS);
        if (load_pos < rows * cols) begin
            grid_mem[load_pos] = req.kind;
            if (req.kind == KIND_START) start_pos = load_pos;
            load_pos++;
        end
        if (req.last) begin
            escape_q.push_back(escape_found(rows, cols));
            load_pos = 0;
        end
    endfunction

    task automatic fail_check(input string what, input bit exp, input bit got);
        errors++;
        if (errors <= 10)
            $display("mismatch: %s expected %0d actual %0d", what, exp, got);
    endtask

    // Sender: presents queued cell requests with random gaps.
    always @(posedge i_clk) begin
        t_cell_req req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            idle_left = 0;
        end else if (i_in_valid && !o_in_stall) begin
            load_cell('{kind: i_cell_kind, last: i_last_cell});
            idle_left = draw_wait(send_quiet);
            if (idle_left == 0 && cell_q.size() > 0) begin
                req = cell_q.pop_front();
                i_cell_kind <= req.kind;
                i_last_cell <= req.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end else if (!i_in_valid) begin
            if (idle_left > 0) begin
                idle_left--;
            end else if (cell_q.size() > 0) begin
                req = cell_q.pop_front();
                i_cell_kind <= req.kind;
                i_last_cell <= req.last;
                i_in_valid <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, started on request from the stimulus.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pressure_left <= 0;
            pressure_ack <= 1'b0;
        end else if (pressure_req != pressure_ack) begin
            pressure_left <= 3000;
            pressure_ack <= pressure_req;
        end else if (pressure_left > 0) begin
            pressure_left <= pressure_left - 1;
        end
    end

    // Receiver: checks each answer against the oldest prediction.
    always @(posedge i_clk) begin
        bit exp;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (escape_q.size() == 0) begin
                    fail_check("unexpected answer, escape_possible", 1'b0,
                               o_escape_possible);
                end else begin
                    exp = escape_q.pop_front();
                    if (o_escape_possible !== exp)
                        fail_check("escape_possible", exp, o_escape_possible);
                end
                hold_left = draw_wait(recv_quiet);
            end else if (hold_left > 0) begin
                hold_left--;
            end
            i_out_stall <= (hold_left > 0) || (pressure_left > 0);
        end
    end

    task automatic push_cell(input logic [KIND_W-1:0] kind, input bit last);
        cell_q.push_back('{kind: kind, last: last});
        if (gen_pos < gen_cells) gen_written[gen_pos] = 1'b1;
        gen_pos = last ? 0 : gen_pos + 1;
    endtask

    task automatic queue_grid(input logic [KIND_W-1:0] kinds[$]);
        foreach (kinds[i]) push_cell(kinds[i], i == kinds.size() - 1);
    endtask

    // One random grid; returns the number of requests queued.
    task automatic random_grid(output int n);
        int sp;
        int r;
        int n_min;
        bit has_start;
        logic [KIND_W-1:0] kind;
        sp = $urandom_range(0, gen_cells - 1);
        has_start = ($urandom_range(0, 7) != 0);
        r = $urandom_range(0, 9);
        if (r == 0) n = $urandom_range(1, gen_cells);
        else if (r == 1) n = gen_cells + $urandom_range(1, 4);
        else n = gen_cells;
        // Never leave a cell that was never written inside the grid.
        n_min = 0;
        for (int i = gen_cells - 1; i >= 0; i--) begin
            if (!gen_written[i]) begin
                n_min = i + 1;
                break;
            end
        end
        if (n < n_min) n = n_min;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (i == sp && has_start) kind = KIND_START;
            else if (r < 50) kind = KIND_OPEN;
            else if (r < 72) kind = KIND_WALL;
            else if (r < 82) kind = KIND_EXIT;
            else if (r < 90) kind = KIND_FIRE;
            else if (r < 94) kind = KIND_START;
            else kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            push_cell(kind, i == n - 1);
        end
    endtask

    task automatic wait_idle();
        while (cell_q.size() != 0 || i_in_valid || escape_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx == CFG_ROWS) rows_cfg = data;
        else cols_cfg = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
        wait_idle();
        cfg_write(CFG_ROWS, r);
        cfg_write(CFG_COLS, c);
        gen_cells = eff_dim(r, MAX_ROWS) * eff_dim(c, MAX_COLS);
    endtask

    // Stimulus: directed grids first, then random grids in several geometries.
    initial begin
        logic [CFG_W-1:0] r;
        logic [CFG_W-1:0] c;
        int n;
        int phase_items;
        errors = 0;
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        pressure_req = 1'b0;
        rows_cfg = 9'd256;
        cols_cfg = 9'd256;
        start_pos = 0;
        load_pos = 0;
        gen_pos = 0;
        gen_cells = CELLS_MAX;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ROWS;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_cell_kind = KIND_OPEN;
        i_last_cell = 1'b0;
        i_out_stall = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A row of three cells; zero rows counts as one.
        set_geometry(9'd0, 9'd3);
        queue_grid('{KIND_START, KIND_OPEN, KIND_EXIT});
        queue_grid('{KIND_START, KIND_EXIT, KIND_FIRE});
        queue_grid('{KIND_FIRE, KIND_START, KIND_EXIT});
        queue_grid('{KIND_START, KIND_FIRE, KIND_EXIT});
        queue_grid('{KIND_START, KIND_WALL, KIND_EXIT});
        queue_grid('{KIND_EXIT, KIND_START, KIND_SPARE_HI});
        // Too many cells, then a short grid, then a grid without a start.
        queue_grid('{KIND_START, KIND_OPEN, KIND_EXIT, KIND_WALL, KIND_WALL});
        queue_grid('{KIND_OPEN});
        queue_grid('{KIND_WALL, KIND_OPEN, KIND_EXIT});

        for (int ph = 0; ph < 14; ph++) begin
            case (ph)
                0: begin r = 9'd256; c = 9'd1; end
                1: begin r = 9'd1; c = 9'd256; end
                2: begin r = 9'd511; c = 9'd0; end
                3: begin r = 9'd0; c = 9'd511; end
                default: begin
                    r = CFG_W'($urandom_range(0, 9));
                    c = CFG_W'($urandom_range(0, 9));
                end
            endcase
            set_geometry(r, c);
            if (ph == 7) pressure_req <= ~pressure_req;
            phase_items = 0;
            while (phase_items < 100) begin
                random_grid(n);
                phase_items += n;
            end
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #8000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
